### hdl/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// Shared widths, types, register indexes and helpers for the camera ray
// direction pipeline.
// ----------------------------------------------------------------------------
package crd_pkg;

	localparam int PIXEL_BITS    = 11;
	localparam int DIR_FRAC_BITS = 14;

	localparam int PIX_IN_W = 11;
	localparam int OUT_W    = 16;
	localparam int COMP_W   = 21;
	localparam int REG_W    = 63;
	localparam int NREG     = 4;
	localparam int IDX_W    = 2;

	// pixel centre arithmetic
	localparam int PROD_W = COMP_W + PIXEL_BITS + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int MAG_W  = PROD_W;

	// normalisation: largest magnitude lands in [2^29, 2^30)
	localparam int NORM_W = 30;
	localparam int XW     = MAG_W + NORM_W;
	localparam int POS_W  = $clog2(XW);

	// square root
	localparam int SQ_W       = 2 * NORM_W + 2;
	localparam int RES_W      = SQ_W + 1;
	localparam int ROOT_STEPS = NORM_W + 1;
	localparam int LEN_W      = NORM_W + 1;

	// division
	localparam int Q_W   = DIR_FRAC_BITS + 1;
	localparam int NUM_W = NORM_W + DIR_FRAC_BITS + 1;
	localparam int NEG_W = (Q_W > OUT_W) ? Q_W + 1 : OUT_W + 1;

	localparam logic [IDX_W-1:0] REG_FIRST = 2'd0;
	localparam logic [IDX_W-1:0] REG_COL   = 2'd1;
	localparam logic [IDX_W-1:0] REG_ROW   = 2'd2;
	localparam logic [IDX_W-1:0] REG_CAM   = 2'd3;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [2:0][MAG_W-1:0]    mvec_t;
	typedef logic [2:0][NORM_W-1:0]   nvec_t;
	typedef logic [2:0][LEN_W-1:0]    rvec_t;
	typedef logic [2:0][Q_W-1:0]      qvec_t;

	function automatic comp_t comp_of(input logic [REG_W-1:0] r, input int i);
		comp_of = r[i*COMP_W +: COMP_W];
	endfunction

endpackage

### hdl/crd_pix_if.sv
// ----------------------------------------------------------------------------
// crd_pix_if
// Pixel coordinate channel: valid, ready and one pixel column and row.
// ----------------------------------------------------------------------------
interface crd_pix_if;
	import crd_pkg::*;

	logic                valid;
	logic                ready;
	logic [PIX_IN_W-1:0] pixel_column;
	logic [PIX_IN_W-1:0] pixel_row;

	modport source (output valid, output pixel_column, output pixel_row, input ready);
	modport sink   (input valid, input pixel_column, input pixel_row, output ready);

endinterface

### hdl/crd_ray_if.sv
// ----------------------------------------------------------------------------
// crd_ray_if
// Ray direction channel: valid, ready, unit direction and degenerate flag.
// ----------------------------------------------------------------------------
interface crd_ray_if;
	import crd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] direction_x;
	logic signed [OUT_W-1:0] direction_y;
	logic signed [OUT_W-1:0] direction_z;
	logic                    degenerate;

	modport source (output valid, output direction_x, output direction_y,
		output direction_z, output degenerate, input ready);
	modport sink   (input valid, input direction_x, input direction_y,
		input direction_z, input degenerate, output ready);

endinterface

### hdl/camera_ray_direction.sv
// ----------------------------------------------------------------------------
// camera_ray_direction
// Unit direction of the primary ray through a pixel centre, fixed point.
// ----------------------------------------------------------------------------
//
//  channel  dir  protocol     payload
//  pix      in   valid/ready  pixel_column, pixel_row
//  ray      out  valid/ready  direction_x/y/z (Q1.14), degenerate
//  cfg      in   write only   cfg_we, cfg_index, cfg_data (63 bits)
//
//  one item per cycle while the pipeline advances; most stages belong to
//  the bit-per-stage square root (31 stages) and restoring divider (15 stages)
//  the whole pipeline advances together whenever the output register is
//  empty or being taken; otherwise every stage holds
//  arst_n clears the valid bits and the configuration registers
//
module camera_ray_direction (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [crd_pkg::IDX_W-1:0]  cfg_index,
	input  logic [crd_pkg::REG_W-1:0]  cfg_data,
	crd_pix_if.sink                    pix,
	crd_ray_if.source                  ray
);
	import crd_pkg::*;

	// configuration registers
	logic [REG_W-1:0] first_q, col_q, row_q, cam_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			cam_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRST: first_q <= cfg_data;
				REG_COL:   col_q   <= cfg_data;
				REG_ROW:   row_q   <= cfg_data;
				REG_CAM:   cam_q   <= cfg_data;
				default:   ;
			endcase
		end
	end

	// global advance: output register free or being drained
	logic out_v_q;
	logic en;
	assign en        = !out_v_q || ray.ready;
	assign pix.ready = en;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rt_v [0:ROOT_STEPS];
	logic dv_v [0:Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= pix.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			out_v_q <= dv_v[Q_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v[0] <= 1'b0;
		end else if (en) begin
			rt_v[0] <= v_s5;
		end
	end

	// stage 1: column and row products per component
	prod_t pc_s1 [0:2];
	prod_t pr_s1 [0:2];
	logic [PIXEL_BITS-1:0] col_pix, row_pix;
	assign col_pix = pix.pixel_column[PIXEL_BITS-1:0];
	assign row_pix = pix.pixel_row[PIXEL_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pc_s1[i] <= comp_of(col_q, i) * $signed({1'b0, col_pix});
				pr_s1[i] <= comp_of(row_q, i) * $signed({1'b0, row_pix});
			end
		end
	end

	// stage 2: centre minus camera, split into sign and magnitude
	logic [2:0] neg_s2;
	mvec_t      mag_s2;
	logic signed [SUM_W-1:0] diff [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = SUM_W'(comp_of(first_q, i)) + SUM_W'(pc_s1[i])
				+ SUM_W'(pr_s1[i]) - SUM_W'(comp_of(cam_q, i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s2[i] <= diff[i][SUM_W-1];
				mag_s2[i] <= diff[i][SUM_W-1] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
			end
		end
	end

	// stage 3: leading one of the largest magnitude (same as of the or)
	logic [2:0]       neg_s3;
	mvec_t            mag_s3;
	logic [POS_W-1:0] pos_s3;
	logic             zero_s3;
	logic [MAG_W-1:0] mag_or;
	logic [POS_W-1:0] pos_c;

	always_comb begin
		mag_or = mag_s2[0] | mag_s2[1] | mag_s2[2];
		pos_c  = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (mag_or[b]) pos_c = POS_W'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3  <= neg_s2;
			mag_s3  <= mag_s2;
			pos_s3  <= pos_c;
			zero_s3 <= (mag_or == '0);
		end
	end

	// stage 4: common shift, right shifts truncate
	logic [2:0] neg_s4;
	nvec_t      nm_s4;
	logic       zero_s4;
	nvec_t      nm_c;
	logic [XW-1:0] wide [0:2];
	localparam logic [POS_W-1:0] TOP = POS_W'(NORM_W - 1);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s3 >= TOP) wide[i] = XW'(mag_s3[i]) >> (pos_s3 - TOP);
			else               wide[i] = XW'(mag_s3[i]) << (TOP - pos_s3);
			nm_c[i] = wide[i][NORM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s4  <= neg_s3;
			nm_s4   <= nm_c;
			zero_s4 <= zero_s3;
		end
	end

	// stage 5: squares
	logic [2:0]          neg_s5;
	nvec_t               nm_s5;
	logic                zero_s5;
	logic [2*NORM_W-1:0] sq_s5 [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s5  <= neg_s4;
			nm_s5   <= nm_s4;
			zero_s5 <= zero_s4;
			for (int i = 0; i < 3; i++) sq_s5[i] <= nm_s4[i] * nm_s4[i];
		end
	end

	// stage 6: sum of squares, feeds the root pipeline at index 0
	logic [SQ_W-1:0]  rt_n    [0:ROOT_STEPS];
	logic [RES_W-1:0] rt_r    [0:ROOT_STEPS];
	nvec_t            rt_nm   [0:ROOT_STEPS];
	logic [2:0]       rt_neg  [0:ROOT_STEPS];
	logic             rt_zero [0:ROOT_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			rt_n[0]    <= SQ_W'(sq_s5[0]) + SQ_W'(sq_s5[1]) + SQ_W'(sq_s5[2]);
			rt_r[0]    <= '0;
			rt_nm[0]   <= nm_s5;
			rt_neg[0]  <= neg_s5;
			rt_zero[0] <= zero_s5;
		end
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (ROOT_STEPS - 1 - k));
		logic [RES_W-1:0] trial;
		logic             take;

		assign trial = rt_r[k] + BIT;
		assign take  = {1'b0, rt_n[k]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v[k+1] <= 1'b0;
			end else if (en) begin
				rt_v[k+1] <= rt_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_n[k+1]    <= take ? rt_n[k] - trial[SQ_W-1:0] : rt_n[k];
				rt_r[k+1]    <= take ? (rt_r[k] >> 1) + BIT : rt_r[k] >> 1;
				rt_nm[k+1]   <= rt_nm[k];
				rt_neg[k+1]  <= rt_neg[k];
				rt_zero[k+1] <= rt_zero[k];
			end
		end
	end

	// divider set-up: numerator a*2^F + len/2, quotient fits Q_W bits
	logic [LEN_W-1:0] len_c;
	logic [NUM_W-1:0] num_c [0:2];
	assign len_c = rt_r[ROOT_STEPS][LEN_W-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = (NUM_W'(rt_nm[ROOT_STEPS][i]) << DIR_FRAC_BITS)
				+ NUM_W'(len_c >> 1);
		end
	end

	rvec_t            dv_rem  [0:Q_W];
	qvec_t            dv_low  [0:Q_W];
	qvec_t            dv_qt   [0:Q_W];
	logic [LEN_W-1:0] dv_len  [0:Q_W];
	logic [2:0]       dv_neg  [0:Q_W];
	logic             dv_zero [0:Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= rt_v[ROOT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= LEN_W'(num_c[i][NUM_W-1:Q_W]);
				dv_low[0][i] <= num_c[i][Q_W-1:0];
				dv_qt[0][i]  <= '0;
			end
			dv_len[0]  <= len_c;
			dv_neg[0]  <= rt_neg[ROOT_STEPS];
			dv_zero[0] <= rt_zero[ROOT_STEPS];
		end
	end

	// restoring division, one quotient bit per stage, three lanes
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		logic [LEN_W:0] part [0:2];
		logic [2:0]     ge;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				part[i] = {dv_rem[j][i], dv_low[j][i][Q_W-1]};
				ge[i]   = part[i] >= {1'b0, dv_len[j]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem[j+1][i] <= ge[i] ? LEN_W'(part[i] - {1'b0, dv_len[j]})
						: part[i][LEN_W-1:0];
					dv_low[j+1][i] <= dv_low[j][i] << 1;
					dv_qt[j+1][i]  <= {dv_qt[j][i][Q_W-2:0], ge[i]};
				end
				dv_len[j+1]  <= dv_len[j];
				dv_neg[j+1]  <= dv_neg[j];
				dv_zero[j+1] <= dv_zero[j];
			end
		end
	end

	// output stage: clamp to one, apply sign, cut to field width
	localparam logic [Q_W-1:0] ONE = Q_W'(1) << DIR_FRAC_BITS;
	logic [OUT_W-1:0] dir_c [0:2];
	logic [Q_W-1:0]   qc    [0:2];
	logic [NEG_W-1:0] sv    [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (dv_qt[Q_W][i] > ONE) ? ONE : dv_qt[Q_W][i];
			sv[i] = dv_neg[Q_W][i] ? NEG_W'(-NEG_W'(qc[i])) : NEG_W'(qc[i]);
			dir_c[i] = dv_zero[Q_W] ? '0 : sv[i][OUT_W-1:0];
		end
	end

	logic [OUT_W-1:0] dir_x_q, dir_y_q, dir_z_q;
	logic             deg_q;

	always_ff @(posedge clk) begin
		if (en) begin
			dir_x_q <= dir_c[0];
			dir_y_q <= dir_c[1];
			dir_z_q <= dir_c[2];
			deg_q   <= dv_zero[Q_W];
		end
	end

	assign ray.valid       = out_v_q;
	assign ray.direction_x = $signed(dir_x_q);
	assign ray.direction_y = $signed(dir_y_q);
	assign ray.direction_z = $signed(dir_z_q);
	assign ray.degenerate  = deg_q;

`ifndef SYNTHESIS
	// degenerate rays carry a zero direction
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ray.valid && ray.degenerate) |->
		(ray.direction_x == '0 && ray.direction_y == '0 && ray.direction_z == '0))
		else $error("degenerate ray with nonzero direction");

	// after the shift the largest magnitude has its top bit set
	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !zero_s4) |->
		(nm_s4[0][NORM_W-1] || nm_s4[1][NORM_W-1] || nm_s4[2][NORM_W-1]))
		else $error("normalisation left the top bit clear");

	// root of a normalised vector is at least 2^29
	a_len_min: assert property (@(posedge clk) disable iff (!arst_n)
		(rt_v[ROOT_STEPS] && !rt_zero[ROOT_STEPS]) |->
		(rt_r[ROOT_STEPS][LEN_W-1:NORM_W-1] != '0))
		else $error("vector length below normalised range");

	// a valid non-degenerate ray has some nonzero component
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ray.valid && !ray.degenerate) |->
		(ray.direction_x != '0 || ray.direction_y != '0 || ray.direction_z != '0))
		else $error("non-degenerate ray with zero direction");
`endif

endmodule

### bench/crd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crd_checker
// Watches the pixel, ray and configuration ports, predicts the unit ray
// direction of every accepted pixel and compares it with the ray items.
// ----------------------------------------------------------------------------
module crd_checker
	import crd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [REG_W-1:0]   cfg_data,
	crd_pix_if                 pix,
	crd_ray_if                 ray,
	output int                 failures,
	output int                 pending
);

	typedef struct packed {
		logic signed [OUT_W-1:0] dx;
		logic signed [OUT_W-1:0] dy;
		logic signed [OUT_W-1:0] dz;
		logic                    degen;
	} ray_dir_t;

	logic [REG_W-1:0] first_loc, col_step, row_step, cam_pos;
	ray_dir_t         ray_queue[$];

	assign pending = ray_queue.size();

	function automatic longint signed comp_val(input logic [REG_W-1:0] r, input int i);
		logic signed [COMP_W-1:0] c;
		c = r[i*COMP_W +: COMP_W];
		return longint'(c);
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   -= res + bitv;
				res  = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic ray_dir_t predict_dir(input logic [PIX_IN_W-1:0] col_in,
			input logic [PIX_IN_W-1:0] row_in);
		longint signed   col, row, d;
		longint unsigned mag[3];
		longint unsigned m, s, len, q, one;
		logic            neg[3];
		logic [OUT_W-1:0] outv[3];
		ray_dir_t        r;
		col = longint'(col_in & ((1 << PIXEL_BITS) - 1));
		row = longint'(row_in & ((1 << PIXEL_BITS) - 1));
		m   = 0;
		for (int i = 0; i < 3; i++) begin
			d = comp_val(first_loc, i) + comp_val(col_step, i) * col
				+ comp_val(row_step, i) * row - comp_val(cam_pos, i);
			neg[i] = d < 0;
			mag[i] = neg[i] ? longint'(-d) : longint'(d);
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) begin
			r = '0;
			r.degen = 1'b1;
			return r;
		end
		while (m >= (64'd1 << NORM_W)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (m < (64'd1 << (NORM_W - 1))) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		s   = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		len = floor_sqrt(s);
		one = 64'd1 << DIR_FRAC_BITS;
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << DIR_FRAC_BITS) + (len >> 1)) / len;
			if (q > one) q = one;
			outv[i] = neg[i] ? OUT_W'(0 - q) : OUT_W'(q);
		end
		r.dx    = outv[0];
		r.dy    = outv[1];
		r.dz    = outv[2];
		r.degen = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ray_dir_t want, got;
		if (!arst_n) begin
			first_loc <= '0;
			col_step  <= '0;
			row_step  <= '0;
			cam_pos   <= '0;
			failures  <= 0;
			ray_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST: first_loc <= cfg_data;
					REG_COL:   col_step  <= cfg_data;
					REG_ROW:   row_step  <= cfg_data;
					REG_CAM:   cam_pos   <= cfg_data;
					default: ;
				endcase
			end
			if (pix.valid && pix.ready)
				ray_queue.push_back(predict_dir(pix.pixel_column, pix.pixel_row));
			if (ray.valid && ray.ready) begin
				got = '{ray.direction_x, ray.direction_y, ray.direction_z, ray.degenerate};
				if (ray_queue.size() == 0) begin
					$display("%0t: unexpected ray item, actual %h", $time, got);
					failures <= failures + 1;
				end else begin
					want = ray_queue.pop_front();
					if (got.dx !== want.dx || got.dy !== want.dy || got.dz !== want.dz
							|| got.degen !== want.degen) begin
						$display("%0t: ray mismatch, expected x %0d y %0d z %0d deg %b, actual x %0d y %0d z %0d deg %b",
							$time, want.dx, want.dy, want.dz, want.degen,
							got.dx, got.dy, got.dz, got.degen);
						failures <= failures + 1;
					end
				end
			end
		end
	end

endmodule

### bench/camera_ray_direction_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_ray_direction_tb
// Programs camera geometries and streams pixels through the ray direction
// pipeline with random idling on both channels; a checker predicts each ray.
// ----------------------------------------------------------------------------
module camera_ray_direction_tb;
	import crd_pkg::*;

	localparam int LATENCY     = 54;
	localparam int CYCLE_LIMIT = 600000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;
	logic             calm;      // no idling in the closing stretch
	int               failures;
	int               pending;
	int               cycles = 0;

	crd_pix_if pix ();
	crd_ray_if ray ();

	camera_ray_direction dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.ray       (ray)
	);

	crd_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.ray       (ray),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog on a cycle count
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// packs three Q10.10 components as z, y, x
	function automatic logic [REG_W-1:0] vec3(input int x, input int y, input int z);
		logic [COMP_W-1:0] cx, cy, cz;
		cx = x[COMP_W-1:0];
		cy = y[COMP_W-1:0];
		cz = z[COMP_W-1:0];
		return {cz, cy, cx};
	endfunction

	function automatic logic [REG_W-1:0] rand_reg();
		return REG_W'({$urandom, $urandom});
	endfunction

	// small signed component, around a few units in Q10.10
	function automatic int near_comp(input int span);
		return $urandom_range(2 * span, 0) - span;
	endfunction

	// one register write, only while the pipeline is quiet
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_camera(input logic [REG_W-1:0] f, input logic [REG_W-1:0] c,
			input logic [REG_W-1:0] r, input logic [REG_W-1:0] cam);
		write_reg(REG_FIRST, f);
		write_reg(REG_COL, c);
		write_reg(REG_ROW, r);
		write_reg(REG_CAM, cam);
	endtask

	// every item gives a ray, so an empty store means the pipeline is drained
	task automatic drain();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 6) @(posedge clk);
	endtask

	// offers one pixel item; valid stays high into the next item unless a gap is taken
	task automatic send_pixel(input logic [PIX_IN_W-1:0] col, input logic [PIX_IN_W-1:0] row);
		if (!calm && $urandom_range(3, 0) == 0) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(17, 1)) @(posedge clk);
		end
		pix.valid        <= 1'b1;
		pix.pixel_column <= col;
		pix.pixel_row    <= row;
		do @(posedge clk); while (!pix.ready);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(1, 0))
				send_pixel(PIX_IN_W'($urandom_range(2047, 0)),
					PIX_IN_W'($urandom_range(2047, 0)));
			else
				send_pixel(PIX_IN_W'($urandom_range(15, 0)),
					PIX_IN_W'($urandom_range(15, 0)));
		end
	endtask

	// receiver stalls in bursts, or takes every item once calm
	initial begin
		ray.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(2, 0) == 0) begin
				ray.ready <= 1'b0;
				repeat ($urandom_range(17, 1)) @(posedge clk);
			end else begin
				ray.ready <= 1'b1;
				repeat ($urandom_range(17, 1)) @(posedge clk);
			end
		end
	end

	initial begin
		int x, y, z;
		arst_n           = 1'b0;
		calm             = 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_FIRST;
		cfg_data         <= '0;
		pix.valid        <= 1'b0;
		pix.pixel_column <= '0;
		pix.pixel_row    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: everything sits on the camera, degenerate rays
		send_pixel(11'd0, 11'd0);
		send_pixel(11'd2047, 11'd2047);
		drain();

		// axis-aligned steps: pixel 0,0 on the camera, pure axes clamp to one
		set_camera(vec3(0, 0, 0), vec3(1, 0, 0), vec3(0, 1, 0), vec3(0, 0, 0));
		send_pixel(11'd0, 11'd0);
		send_pixel(11'd1, 11'd0);
		send_pixel(11'd0, 11'd1);
		send_pixel(11'd2047, 11'd0);
		send_pixel(11'd0, 11'd2047);
		send_pixel(11'd5, 11'd5);
		drain();

		// field extremes: largest magnitudes, right shifts in normalisation
		set_camera(vec3(1048575, -1048576, 5), vec3(-1048576, 1048575, -1048576),
			vec3(1048575, 1048575, -1048576), vec3(-1048576, 1048575, 1048575));
		send_pixel(11'd0, 11'd0);
		send_pixel(11'd2047, 11'd0);
		send_pixel(11'd0, 11'd2047);
		send_pixel(11'd2047, 11'd2047);
		send_pixel(11'd1024, 11'd1023);
		drain();

		// all-ones registers: every component minus one
		set_camera({REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}}, '0);
		send_pixel(11'd0, 11'd0);
		send_pixel(11'd2047, 11'd2047);
		send_pixel(11'd1365, 11'd682);
		drain();

		// random phases; realistic cameras mostly, raw bit patterns sometimes
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 7) calm = 1'b1;
			if (phase % 3 == 2) begin
				set_camera(rand_reg(), rand_reg(), rand_reg(), rand_reg());
			end else begin
				x = near_comp(4096);
				y = near_comp(4096);
				z = near_comp(4096);
				set_camera(vec3(x, y, z - 1024), vec3(near_comp(8), near_comp(2), 0),
					vec3(near_comp(2), near_comp(8), 0), vec3(x, y, z));
			end
			send_random(47);
			drain();
		end

		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### sim.f
hdl/crd_pkg.sv
hdl/crd_pix_if.sv
hdl/crd_ray_if.sv
hdl/camera_ray_direction.sv
bench/crd_checker.sv
bench/camera_ray_direction_tb.sv
